FILE: rtl/chh_pkg.sv
// Shared definitions for the coordinate chained hash table: default sizes,
// hash multipliers, action and status codes.
// No dependencies; used by chh_hash and coord_chained_hash_table.
package chh_pkg;

    localparam int BUCKETS_DEF     = 4096;
    localparam int ENTRIES_DEF     = 512;
    localparam int COORD_BITS_DEF  = 16;
    localparam int HANDLE_BITS_DEF = 16;

    localparam logic [31:0] HASH_MUL_X = 32'h8da6b343;
    localparam logic [31:0] HASH_MUL_Y = 32'hd8163841;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    localparam int STATUS_W = 2;
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_POOL_FULL = 2'd2;

endpackage

FILE: rtl/chh_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module chh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/chh_hash.sv
// Bucket hash unit: multiplies the sign-extended coordinates by the hash
// constants, XORs the products and reduces the word modulo BUCKETS with a
// reciprocal multiplication and two corrective subtractions. Depends on chh_pkg.
module chh_hash #(
    parameter int BUCKETS    = chh_pkg::BUCKETS_DEF,
    parameter int COORD_BITS = chh_pkg::COORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [COORD_BITS-1:0]  i_key_x,
    input  logic signed [COORD_BITS-1:0]  i_key_y,
    output logic                          o_done,
    output logic [$clog2(BUCKETS)-1:0]    o_bucket
);

    localparam int BW  = $clog2(BUCKETS);
    // The quotient estimate is ((h >> (BW-1)) * MU) >> (34-BW) with
    // MU = floor(2^33 / BUCKETS). It is at most two below the true quotient,
    // so the remainder estimate lies below 3*BUCKETS and fits in BW+2 bits.
    localparam int AW  = 33 - BW;
    localparam int MW  = 34 - BW;
    localparam int PW  = AW + MW;
    localparam int RMW = BW + 2;
    localparam logic [MW-1:0] MU = MW'((64'd1 << 33) / 64'(BUCKETS));

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_LOAD = 2'd1;
    localparam logic [1:0] PH_QUOT = 2'd2;
    localparam logic [1:0] PH_REM  = 2'd3;

    logic [1:0]     r_phase, n_phase;
    logic           r_done, n_done;
    logic [31:0]    r_px, r_py, r_h, n_h;
    logic [AW-1:0]  r_q, n_q;
    logic [BW-1:0]  r_rem, n_rem;
    logic [PW-1:0]  prod;
    logic [RMW-1:0] est_rem, red_rem;
    logic [31:0]    sx, sy;

    assign sx = 32'(i_key_x);
    assign sy = 32'(i_key_y);

    assign prod = PW'(r_h[31:BW-1]) * PW'(MU);

    // Remainder from the estimated quotient; only the low BW+2 bits matter.
    always_comb begin
        est_rem = r_h[RMW-1:0] - RMW'(RMW'(r_q) * RMW'(BUCKETS));
        red_rem = est_rem;
        if (red_rem >= RMW'(BUCKETS)) begin
            red_rem = red_rem - RMW'(BUCKETS);
        end
        if (red_rem >= RMW'(BUCKETS)) begin
            red_rem = red_rem - RMW'(BUCKETS);
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_done  = 1'b0;
        n_h     = r_h;
        n_q     = r_q;
        n_rem   = r_rem;
        case (r_phase)
            PH_IDLE: begin
                if (i_start) begin
                    n_phase = PH_LOAD;
                end
            end
            PH_LOAD: begin
                n_h     = r_px ^ r_py;
                n_phase = PH_QUOT;
            end
            PH_QUOT: begin
                n_q     = prod[PW-1:MW];
                n_phase = PH_REM;
            end
            PH_REM: begin
                n_rem   = red_rem[BW-1:0];
                n_done  = 1'b1;
                n_phase = PH_IDLE;
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_done  <= n_done;
        end
        if (i_start) begin
            r_px <= 32'(sx * chh_pkg::HASH_MUL_X);
            r_py <= 32'(sy * chh_pkg::HASH_MUL_Y);
        end
        r_h   <= n_h;
        r_q   <= n_q;
        r_rem <= n_rem;
    end

    assign o_done   = r_done;
    assign o_bucket = r_rem;

endmodule

FILE: rtl/coord_chained_hash_table.sv
// Coordinate chained hash table, top level: stream ports, control sequencer,
// bucket memory and entry pool memory. Depends on chh_pkg, chh_ram, chh_hash.
//
// This block stores (key_x, key_y) -> handle pairs in a fixed pool of ENTRIES
// entries, chained per bucket, and answers one result transaction for every
// input transaction: an insert answers ok, or pool full once all entries are
// used; a lookup answers the handle of the earliest inserted entry with the
// same key, or not found. After reset the block clears the bucket memory
// with s_axis_tready low. Items are handled one at a time; s_axis_tready is
// high only while the sequencer is idle. The hash is computed in steps: a
// registered multiply of each coordinate, the XOR of the products, a
// reciprocal multiplication that estimates the quotient, and a fix-up of
// the remainder. An insert into a bucket that already has a chain also
// reads the tail entry and writes it back, and a lookup makes one read of
// the pool memory for each chain entry that it visits. An insert into a
// full pool skips the hash and goes straight to the result register. The
// sequencer returns to idle as the result is loaded, and a result waits in
// ST_RESP while the previous result still waits on m_axis_tready. The
// result register lets the next transaction be accepted while the previous
// result still waits on m_axis_tready.
module coord_chained_hash_table #(
    parameter int BUCKETS     = chh_pkg::BUCKETS_DEF,
    parameter int ENTRIES     = chh_pkg::ENTRIES_DEF,
    parameter int COORD_BITS  = chh_pkg::COORD_BITS_DEF,
    parameter int HANDLE_BITS = chh_pkg::HANDLE_BITS_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          s_axis_tvalid,
    output logic                                          s_axis_tready,
    // Fields from bit 0 up: key_x, key_y, entry_handle, zero padding.
    input  logic [((2*COORD_BITS+HANDLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    // Field: action (0 insert, 1 lookup).
    input  logic [0:0]                                    s_axis_tuser,
    output logic                                          m_axis_tvalid,
    input  logic                                          m_axis_tready,
    // Fields from bit 0 up: found_handle, zero padding.
    output logic [((HANDLE_BITS+7)/8)*8-1:0]              m_axis_tdata,
    // Field: status (0 ok or found, 1 not found, 2 pool full).
    output logic [chh_pkg::STATUS_W-1:0]                  m_axis_tuser
);

    localparam int BW = $clog2(BUCKETS);
    localparam int EW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int SW = chh_pkg::STATUS_W;
    localparam int M_TDATA_W = ((HANDLE_BITS + 7) / 8) * 8;

    // Sequencer states.
    localparam logic [2:0] ST_CLEAR = 3'd0;  // sweeping the bucket memory
    localparam logic [2:0] ST_IDLE  = 3'd1;  // ready for a transaction
    localparam logic [2:0] ST_HASH  = 3'd2;  // waiting on the hash unit
    localparam logic [2:0] ST_BKT   = 3'd3;  // bucket word arrives
    localparam logic [2:0] ST_LINK  = 3'd4;  // tail entry arrives, link it
    localparam logic [2:0] ST_WALK  = 3'd5;  // chain entry arrives, compare
    localparam logic [2:0] ST_RESP  = 3'd6;  // hand result to output register

    // A bucket holds a valid flag and the first and last entry of its chain.
    typedef struct packed {
        logic          vld;
        logic [EW-1:0] head;
        logic [EW-1:0] tail;
    } t_bkt_word;

    // A pool entry holds its key, its handle and the link to the next entry.
    typedef struct packed {
        logic [COORD_BITS-1:0]  key_x;
        logic [COORD_BITS-1:0]  key_y;
        logic [HANDLE_BITS-1:0] handle;
        logic                   next_vld;
        logic [EW-1:0]          next;
    } t_pool_word;

    localparam int BKT_W  = $bits(t_bkt_word);
    localparam int POOL_W = $bits(t_pool_word);

    // Control and captured transaction.
    logic [2:0]             r_state, n_state;
    logic [BW-1:0]          r_clr_addr, n_clr_addr;
    logic [CW-1:0]          r_free, n_free;
    logic                   r_act, n_act;
    logic [COORD_BITS-1:0]  r_kx, n_kx;
    logic [COORD_BITS-1:0]  r_ky, n_ky;
    logic [HANDLE_BITS-1:0] r_hdl, n_hdl;
    logic [BW-1:0]          r_bkt, n_bkt;
    logic [EW-1:0]          r_tail, n_tail;
    logic [SW-1:0]          r_res_status, n_res_status;
    logic [HANDLE_BITS-1:0] r_res_handle, n_res_handle;
    logic                   r_out_vld, n_out_vld;
    logic [SW-1:0]          r_out_status, n_out_status;
    logic [HANDLE_BITS-1:0] r_out_handle, n_out_handle;

    // Memory ports.
    logic          bkt_we, bkt_re;
    logic [BW-1:0] bkt_waddr, bkt_raddr;
    t_bkt_word     bkt_wdata, bkt_rdata;
    logic [BKT_W-1:0] bkt_rdata_raw;
    logic          pool_we, pool_re;
    logic [EW-1:0] pool_waddr, pool_raddr;
    t_pool_word    pool_wdata, pool_rdata;
    logic [POOL_W-1:0] pool_rdata_raw;

    // Hash unit.
    logic          hash_start, hash_done;
    logic [BW-1:0] hash_bucket;

    logic [COORD_BITS-1:0]  in_kx, in_ky;
    logic [HANDLE_BITS-1:0] in_hdl;
    logic [EW-1:0]          new_entry;
    logic                   pool_full;
    logic                   key_match;

    assign in_kx  = s_axis_tdata[COORD_BITS-1:0];
    assign in_ky  = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
    assign in_hdl = s_axis_tdata[2*COORD_BITS+HANDLE_BITS-1:2*COORD_BITS];

    assign new_entry = r_free[EW-1:0];
    assign pool_full = (r_free == CW'(ENTRIES));

    assign bkt_rdata  = t_bkt_word'(bkt_rdata_raw);
    assign pool_rdata = t_pool_word'(pool_rdata_raw);
    assign key_match  = (pool_rdata.key_x == r_kx) && (pool_rdata.key_y == r_ky);

    assign s_axis_tready = (r_state == ST_IDLE);

    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_free       = r_free;
        n_act        = r_act;
        n_kx         = r_kx;
        n_ky         = r_ky;
        n_hdl        = r_hdl;
        n_bkt        = r_bkt;
        n_tail       = r_tail;
        n_res_status = r_res_status;
        n_res_handle = r_res_handle;
        n_out_vld    = r_out_vld & ~m_axis_tready;
        n_out_status = r_out_status;
        n_out_handle = r_out_handle;

        bkt_we     = 1'b0;
        bkt_waddr  = r_bkt;
        bkt_wdata  = '0;
        bkt_re     = 1'b0;
        bkt_raddr  = hash_bucket;
        pool_we    = 1'b0;
        pool_waddr = new_entry;
        pool_wdata = '0;
        pool_re    = 1'b0;
        pool_raddr = bkt_rdata.head;
        hash_start = 1'b0;

        case (r_state)
            ST_CLEAR: begin
                bkt_we    = 1'b1;
                bkt_waddr = r_clr_addr;
                if (r_clr_addr == BW'(BUCKETS - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_clr_addr = BW'(r_clr_addr + 1'b1);
                end
            end
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_act = s_axis_tuser[0];
                    n_kx  = in_kx;
                    n_ky  = in_ky;
                    n_hdl = in_hdl;
                    if ((s_axis_tuser[0] == chh_pkg::ACT_INSERT) && pool_full) begin
                        n_res_status = chh_pkg::STATUS_POOL_FULL;
                        n_res_handle = '0;
                        n_state      = ST_RESP;
                    end else begin
                        hash_start = 1'b1;
                        n_state    = ST_HASH;
                    end
                end
            end
            ST_HASH: begin
                if (hash_done) begin
                    bkt_re    = 1'b1;
                    bkt_raddr = hash_bucket;
                    n_bkt     = hash_bucket;
                    n_state   = ST_BKT;
                end
            end
            ST_BKT: begin
                if (r_act == chh_pkg::ACT_INSERT) begin
                    // The new entry is written now; its index is above every
                    // allocated entry, so it never collides with the tail read.
                    pool_we           = 1'b1;
                    pool_waddr        = new_entry;
                    pool_wdata.key_x  = r_kx;
                    pool_wdata.key_y  = r_ky;
                    pool_wdata.handle = r_hdl;
                    bkt_we            = 1'b1;
                    bkt_waddr         = r_bkt;
                    bkt_wdata.vld     = 1'b1;
                    bkt_wdata.tail    = new_entry;
                    if (!bkt_rdata.vld) begin
                        bkt_wdata.head = new_entry;
                        n_free         = CW'(r_free + 1'b1);
                        n_res_status   = chh_pkg::STATUS_OK;
                        n_res_handle   = '0;
                        n_state        = ST_RESP;
                    end else begin
                        bkt_wdata.head = bkt_rdata.head;
                        pool_re        = 1'b1;
                        pool_raddr     = bkt_rdata.tail;
                        n_tail         = bkt_rdata.tail;
                        n_state        = ST_LINK;
                    end
                end else begin
                    if (!bkt_rdata.vld) begin
                        n_res_status = chh_pkg::STATUS_NOT_FOUND;
                        n_res_handle = '0;
                        n_state      = ST_RESP;
                    end else begin
                        pool_re    = 1'b1;
                        pool_raddr = bkt_rdata.head;
                        n_state    = ST_WALK;
                    end
                end
            end
            ST_LINK: begin
                pool_we             = 1'b1;
                pool_waddr          = r_tail;
                pool_wdata          = pool_rdata;
                pool_wdata.next_vld = 1'b1;
                pool_wdata.next     = new_entry;
                n_free              = CW'(r_free + 1'b1);
                n_res_status        = chh_pkg::STATUS_OK;
                n_res_handle        = '0;
                n_state             = ST_RESP;
            end
            ST_WALK: begin
                if (key_match) begin
                    n_res_status = chh_pkg::STATUS_OK;
                    n_res_handle = pool_rdata.handle;
                    n_state      = ST_RESP;
                end else if (pool_rdata.next_vld) begin
                    pool_re    = 1'b1;
                    pool_raddr = pool_rdata.next;
                end else begin
                    n_res_status = chh_pkg::STATUS_NOT_FOUND;
                    n_res_handle = '0;
                    n_state      = ST_RESP;
                end
            end
            ST_RESP: begin
                if (!r_out_vld || m_axis_tready) begin
                    n_out_vld    = 1'b1;
                    n_out_status = r_res_status;
                    n_out_handle = r_res_handle;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_free     <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_free     <= n_free;
            r_out_vld  <= n_out_vld;
        end
        r_act        <= n_act;
        r_kx         <= n_kx;
        r_ky         <= n_ky;
        r_hdl        <= n_hdl;
        r_bkt        <= n_bkt;
        r_tail       <= n_tail;
        r_res_status <= n_res_status;
        r_res_handle <= n_res_handle;
        r_out_status <= n_out_status;
        r_out_handle <= n_out_handle;
    end

    chh_hash #(
        .BUCKETS    (BUCKETS),
        .COORD_BITS (COORD_BITS)
    ) u_hash (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (hash_start),
        .i_key_x  (in_kx),
        .i_key_y  (in_ky),
        .o_done   (hash_done),
        .o_bucket (hash_bucket)
    );

    chh_ram #(
        .WIDTH (BKT_W),
        .DEPTH (BUCKETS)
    ) u_bkt_ram (
        .i_clk   (i_clk),
        .i_we    (bkt_we),
        .i_waddr (bkt_waddr),
        .i_wdata (bkt_wdata),
        .i_re    (bkt_re),
        .i_raddr (bkt_raddr),
        .o_rdata (bkt_rdata_raw)
    );

    chh_ram #(
        .WIDTH (POOL_W),
        .DEPTH (ENTRIES)
    ) u_pool_ram (
        .i_clk   (i_clk),
        .i_we    (pool_we),
        .i_waddr (pool_waddr),
        .i_wdata (pool_wdata),
        .i_re    (pool_re),
        .i_raddr (pool_raddr),
        .o_rdata (pool_rdata_raw)
    );

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = M_TDATA_W'(r_out_handle);

endmodule
